// ----- src/srw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srw_pkg;

   // Fixed geometry of the window and of the result fields.
   localparam int WIN_DEPTH        = 8;
   localparam int SLOT_W           = $clog2(WIN_DEPTH);
   localparam int CNT_W            = $clog2(WIN_DEPTH) + 1;
   localparam int MODE_W           = 2;
   localparam int OC_W             = 2;
   localparam int STATUS_W         = 3;
   localparam int SEQ_OUT_W        = 4;
   localparam int CSR_W            = 3;
   localparam int EB_W             = 4;
   localparam int MAX_SEQ_BITS_DEF = 4;
   localparam logic [CSR_W-1:0] SEQ_BITS_RESET = 3'd3;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OUTCOME = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SLIDE   = 2'd2;

   // Link outcomes for one slot.
   localparam logic [OC_W-1:0] OC_ACK_OK   = 2'd0;
   localparam logic [OC_W-1:0] OC_ACK_LOST = 2'd1;
   localparam logic [OC_W-1:0] OC_DAMAGED  = 2'd2;
   localparam logic [OC_W-1:0] OC_LOST     = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_SENT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NAK       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOST      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_WRD,
      S_WCHK,
      S_SRCH,
      S_SCAN,
      S_CRD,
      S_CPROC,
      S_FILL,
      S_ONE
   } state_type;

   // One result item as it travels to the output register.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SEQ_OUT_W-1:0] seq_num;
      logic                 ack_received;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/srw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module srw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/srw_rsp_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module srw_rsp_reg import srw_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 ld_valid,
   input  wire rsp_type              ld_data,
   output logic                      free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SEQ_OUT_W-1:0]      rsp_seq_num,
   output logic                      rsp_ack_received,
   output logic                      rsp_last
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    load;

   // The register can take a new result when empty or when its transfer completes.
   assign free = !valid_ff || rsp_ready;
   assign load = ld_valid && free;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= ld_data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = data_ff.status;
   assign rsp_seq_num      = data_ff.seq_num;
   assign rsp_ack_received = data_ff.ack_received;
   assign rsp_last         = data_ff.last;

endmodule

`default_nettype wire

// ----- src/srw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module srw_ctrl import srw_pkg::*; #(
   parameter int MAX_SEQ_BITS = MAX_SEQ_BITS_DEF,
   localparam int SW = MAX_SEQ_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Input items
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [SLOT_W-1:0] req_slot,
   input  wire logic [OC_W-1:0]   req_outcome,
   // Configuration
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_W-1:0]  csr_data,
   // Sender window memory: {acked, seq}
   output logic                   win_wr_en,
   output logic [SLOT_W-1:0]      win_wr_addr,
   output logic [SW:0]            win_wr_data,
   output logic                   win_rd_en,
   output logic [SLOT_W-1:0]      win_rd_addr,
   input  wire logic [SW:0]       win_rd_data,
   // Receiver expected-number memory
   output logic                   exp_wr_en,
   output logic [SLOT_W-1:0]      exp_wr_addr,
   output logic [SW-1:0]          exp_wr_data,
   output logic                   exp_rd_en,
   output logic [SLOT_W-1:0]      exp_rd_addr,
   input  wire logic [SW-1:0]     exp_rd_data,
   // Results towards the output register
   output logic                   emit_valid,
   output rsp_type                emit_data,
   input  wire logic              emit_free
);

   localparam int CW = (SW < SEQ_OUT_W) ? SW : SEQ_OUT_W;
   localparam logic [EB_W-1:0] MAX_B = EB_W'(MAX_SEQ_BITS);
   localparam logic [EB_W-1:0] FULL_B = EB_W'($clog2(WIN_DEPTH) + 1);

   state_type state_ff, state_in;

   logic [CSR_W-1:0]     seq_bits_ff, seq_bits_in;
   logic [SW-1:0]        send_next_ff, send_next_in;
   logic [SW-1:0]        recv_next_ff, recv_next_in;
   logic [WIN_DEPTH-1:0] win_vld_ff, win_vld_in;
   logic [WIN_DEPTH-1:0] exp_vld_ff, exp_vld_in;
   logic                 win_rv_ff, win_rv_in;
   logic                 exp_rv_ff, exp_rv_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [CNT_W-1:0]     dst_ff, dst_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic                 found_ff, found_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_W-1:0]    pidx_ff, pidx_in;

   // Payload registers
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [OC_W-1:0]      oc_ff, oc_in;
   logic [SW-1:0]        seq_ff, seq_in;
   rsp_type              res_ff, res_in;

   logic [EB_W-1:0]      eff_b;
   logic [CNT_W-1:0]     win_size;
   logic [SW-1:0]        mask;
   logic                 req_fire;
   logic                 slot_out;
   logic [SW:0]          win_q;
   logic                 win_q_acked;
   logic [SW-1:0]        win_q_seq;
   logic [SW-1:0]        exp_q;
   logic                 srch_hit;
   logic                 srch_miss;
   logic                 pass_done;
   logic [SW-1:0]        kseq;

   function automatic logic [SEQ_OUT_W-1:0] out_seq(input logic [SW-1:0] s);
      return SEQ_OUT_W'(s[CW-1:0]);
   endfunction

   // Effective sequence bits, modulus mask and window size from the register.
   always_comb begin
      if (seq_bits_ff == '0) begin
         eff_b = EB_W'(1);
      end else if (EB_W'(seq_bits_ff) > MAX_B) begin
         eff_b = MAX_B;
      end else begin
         eff_b = EB_W'(seq_bits_ff);
      end
      if (eff_b >= FULL_B) begin
         win_size = CNT_W'(WIN_DEPTH);
      end else begin
         win_size = CNT_W'(1) << (eff_b - EB_W'(1));
      end
      for (int i = 0; i < SW; i++) begin
         mask[i] = (EB_W'(i) < eff_b);
      end
   end

   // Read data of entries never written reads as zero.
   assign win_q       = win_rv_ff ? win_rd_data : '0;
   assign win_q_acked = win_q[SW];
   assign win_q_seq   = win_q[SW-1:0];
   assign exp_q       = exp_rv_ff ? exp_rd_data : '0;

   // A waiting register write goes ahead of a waiting item.
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_out  = (CNT_W'(req_slot) >= win_size);
   assign kseq      = SW'(k_ff) & mask;

   // A pipelined pass has issued its last read and checked its last data.
   assign pass_done = !pend_ff && (k_ff >= win_size);
   assign srch_hit  = pend_ff && (exp_q == seq_ff);
   assign srch_miss = pass_done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_START:   state_in = S_START;
                  MODE_OUTCOME: state_in = slot_out ? S_ONE : S_WRD;
                  MODE_SLIDE:   state_in = S_SCAN;
                  default:      state_in = S_ONE;
               endcase
            end
         end
         S_START: begin
            if (emit_free && (k_ff + CNT_W'(1) == win_size)) begin
               state_in = S_IDLE;
            end
         end
         S_WRD: state_in = S_WCHK;
         S_WCHK: begin
            if (win_q_acked || (oc_ff == OC_DAMAGED) || (oc_ff == OC_LOST)) begin
               state_in = S_ONE;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (srch_hit || srch_miss) begin
               state_in = S_ONE;
            end
         end
         S_SCAN: begin
            if (pass_done) begin
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            if (k_ff < win_size) begin
               state_in = S_CPROC;
            end else begin
               state_in = S_FILL;
            end
         end
         S_CPROC: begin
            if (win_q_acked || emit_free) begin
               state_in = S_CRD;
            end
         end
         S_FILL: begin
            if (dst_ff >= win_size) begin
               state_in = S_IDLE;
            end else if (emit_free && (dst_ff + CNT_W'(1) == win_size)) begin
               state_in = S_IDLE;
            end
         end
         S_ONE: begin
            if (emit_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory accesses and result emission.
   always_comb begin
      win_wr_en   = 1'b0;
      win_wr_addr = '0;
      win_wr_data = '0;
      win_rd_en   = 1'b0;
      win_rd_addr = '0;
      exp_wr_en   = 1'b0;
      exp_wr_addr = '0;
      exp_wr_data = '0;
      exp_rd_en   = 1'b0;
      exp_rd_addr = '0;
      emit_valid  = 1'b0;
      emit_data   = res_ff;
      case (state_ff)
         S_START: begin
            win_wr_en   = emit_free;
            win_wr_addr = k_ff[SLOT_W-1:0];
            win_wr_data = {1'b0, kseq};
            exp_wr_en   = emit_free;
            exp_wr_addr = k_ff[SLOT_W-1:0];
            exp_wr_data = kseq;
            emit_valid  = 1'b1;
            emit_data.status       = ST_SENT;
            emit_data.seq_num      = out_seq(kseq);
            emit_data.ack_received = 1'b0;
            emit_data.last         = (k_ff + CNT_W'(1) == win_size);
         end
         S_WRD: begin
            win_rd_en   = 1'b1;
            win_rd_addr = slot_ff;
         end
         S_SRCH: begin
            exp_rd_en   = (k_ff < win_size);
            exp_rd_addr = k_ff[SLOT_W-1:0];
            if (srch_hit) begin
               exp_wr_en   = 1'b1;
               exp_wr_addr = pidx_ff;
               exp_wr_data = recv_next_ff & mask;
            end
            if (srch_hit || srch_miss) begin
               win_wr_en   = 1'b1;
               win_wr_addr = slot_ff;
               win_wr_data = {(oc_ff == OC_ACK_OK), seq_ff};
            end
         end
         S_SCAN, S_CRD: begin
            win_rd_en   = (k_ff < win_size);
            win_rd_addr = k_ff[SLOT_W-1:0];
         end
         S_CPROC: begin
            win_wr_en   = win_q_acked || emit_free;
            win_wr_addr = dst_ff[SLOT_W-1:0];
            win_wr_data = win_q;
            emit_valid  = !win_q_acked;
            emit_data.status       = ST_SENT;
            emit_data.seq_num      = out_seq(win_q_seq);
            emit_data.ack_received = 1'b0;
            emit_data.last         = (seen_ff + CNT_W'(1) == cnt_ff);
         end
         S_FILL: begin
            win_wr_en   = emit_free && (dst_ff < win_size);
            win_wr_addr = dst_ff[SLOT_W-1:0];
            win_wr_data = {1'b0, send_next_ff & mask};
            emit_valid  = (dst_ff < win_size);
            emit_data.status       = ST_SENT;
            emit_data.seq_num      = out_seq(send_next_ff & mask);
            emit_data.ack_received = 1'b0;
            emit_data.last         = (seen_ff + CNT_W'(1) == cnt_ff);
         end
         S_ONE: begin
            emit_valid = 1'b1;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      seq_bits_in  = seq_bits_ff;
      send_next_in = send_next_ff;
      recv_next_in = recv_next_ff;
      k_in         = k_ff;
      dst_in       = dst_ff;
      seen_in      = seen_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      slot_in      = slot_ff;
      oc_in        = oc_ff;
      seq_in       = seq_ff;
      res_in       = res_ff;

      // Track which entries have been written, and the flag of each read.
      win_vld_in = win_vld_ff;
      exp_vld_in = exp_vld_ff;
      if (win_wr_en) begin
         win_vld_in[win_wr_addr] = 1'b1;
      end
      if (exp_wr_en) begin
         exp_vld_in[exp_wr_addr] = 1'b1;
      end
      win_rv_in = win_rd_en ? win_vld_ff[win_rd_addr] : win_rv_ff;
      exp_rv_in = exp_rd_en ? exp_vld_ff[exp_rd_addr] : exp_rv_ff;

      if (csr_valid && csr_ready) begin
         seq_bits_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               slot_in  = req_slot;
               oc_in    = req_outcome;
               k_in     = '0;
               dst_in   = '0;
               seen_in  = '0;
               cnt_in   = '0;
               found_in = 1'b0;
               res_in.status       = ST_IGNORED;
               res_in.seq_num      = '0;
               res_in.ack_received = 1'b0;
               res_in.last         = 1'b1;
            end
         end
         S_START: begin
            if (emit_free) begin
               k_in = k_ff + CNT_W'(1);
               if (k_ff + CNT_W'(1) == win_size) begin
                  send_next_in = SW'(win_size) & mask;
                  recv_next_in = SW'(win_size) & mask;
               end
            end
         end
         S_WCHK: begin
            seq_in = win_q_seq;
            k_in   = '0;
            res_in.seq_num = out_seq(win_q_seq);
            if (win_q_acked) begin
               res_in.status       = ST_IGNORED;
               res_in.ack_received = 1'b1;
            end else if (oc_ff == OC_DAMAGED) begin
               res_in.status = ST_NAK;
            end else if (oc_ff == OC_LOST) begin
               res_in.status = ST_LOST;
            end
         end
         S_SRCH: begin
            // One read issued and one compare made every cycle.
            pend_in = (k_ff < win_size);
            pidx_in = k_ff[SLOT_W-1:0];
            if (k_ff < win_size) begin
               k_in = k_ff + CNT_W'(1);
            end
            res_in.ack_received = (oc_ff == OC_ACK_OK);
            if (srch_hit) begin
               res_in.status = ST_ACCEPTED;
               recv_next_in  = ((recv_next_ff & mask) + SW'(1)) & mask;
            end else if (srch_miss) begin
               res_in.status = ST_DUPLICATE;
            end
         end
         S_SCAN: begin
            // Count unacknowledged slots and find the first of them.
            pend_in = (k_ff < win_size);
            pidx_in = k_ff[SLOT_W-1:0];
            if (k_ff < win_size) begin
               k_in = k_ff + CNT_W'(1);
            end
            if (pend_ff && !win_q_acked) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (!found_ff) begin
                  found_in = 1'b1;
                  first_in = CNT_W'(pidx_ff);
               end
            end
            if (pass_done) begin
               // Copying starts at the first unacknowledged slot; every freed
               // slot later adds one fresh pending frame.
               k_in   = found_ff ? first_ff : win_size;
               cnt_in = cnt_ff + (found_ff ? first_ff : win_size);
               dst_in = '0;
            end
         end
         S_CPROC: begin
            if (win_q_acked || emit_free) begin
               k_in   = k_ff + CNT_W'(1);
               dst_in = dst_ff + CNT_W'(1);
               if (!win_q_acked) begin
                  seen_in = seen_ff + CNT_W'(1);
               end
            end
         end
         S_FILL: begin
            if (emit_free && (dst_ff < win_size)) begin
               dst_in       = dst_ff + CNT_W'(1);
               seen_in      = seen_ff + CNT_W'(1);
               send_next_in = ((send_next_ff & mask) + SW'(1)) & mask;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seq_bits_ff  <= SEQ_BITS_RESET;
         send_next_ff <= '0;
         recv_next_ff <= '0;
         win_vld_ff   <= '0;
         exp_vld_ff   <= '0;
         win_rv_ff    <= 1'b0;
         exp_rv_ff    <= 1'b0;
         k_ff         <= '0;
         dst_ff       <= '0;
         seen_ff      <= '0;
         cnt_ff       <= '0;
         first_ff     <= '0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         pidx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         seq_bits_ff  <= seq_bits_in;
         send_next_ff <= send_next_in;
         recv_next_ff <= recv_next_in;
         win_vld_ff   <= win_vld_in;
         exp_vld_ff   <= exp_vld_in;
         win_rv_ff    <= win_rv_in;
         exp_rv_ff    <= exp_rv_in;
         k_ff         <= k_in;
         dst_ff       <= dst_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         pidx_ff      <= pidx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      oc_ff   <= oc_in;
      seq_ff  <= seq_in;
      res_ff  <= res_in;
   end

endmodule

`default_nettype wire

// ----- src/selective_repeat_window.sv -----
// Selective-repeat ARQ sender window with its receiver's list of expected numbers.
// Items arrive on the req_ channel (mode, slot, outcome) and each produces one
// or more results on the rsp_ channel; the final result of an item carries
// rsp_last. The csr_ channel writes the number of sequence bits; it is taken
// only between items and goes ahead of an item that is waiting.
// Results, with W the window size (1 to 8 slots):
//   start:   W results, one per cycle while the output does not stall.
//   outcome: 1 result; a delivered outcome on an unacknowledged slot inside
//            the window first searches the expected list one entry a cycle.
//   slide:   a scan of the window, then a read and a write per kept slot and
//            a write per refilled slot, with a result for each unacknowledged
//            slot that is kept and for each refilled slot.
// The window and the expected list each sit in a small memory with a registered
// read, so every slot costs a read before it can be used.
// A new item is taken as soon as the sequencer is back at rest, even while the
// final result still waits in the output register.
// When the receiver stalls, the sequencer holds at the step that emits the next
// result. After reset the number of sequence bits is 3 and both memories read as
// zero through per-entry written flags; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_window import srw_pkg::*; #(
   parameter int MAX_SEQ_BITS = MAX_SEQ_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [SLOT_W-1:0]    req_slot,
   input  wire logic [OC_W-1:0]      req_outcome,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SEQ_OUT_W-1:0]      rsp_seq_num,
   output logic                      rsp_ack_received,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_W-1:0]     csr_data
);

   localparam int SW = MAX_SEQ_BITS;

   logic              win_wr_en;
   logic [SLOT_W-1:0] win_wr_addr;
   logic [SW:0]       win_wr_data;
   logic              win_rd_en;
   logic [SLOT_W-1:0] win_rd_addr;
   logic [SW:0]       win_rd_data;
   logic              exp_wr_en;
   logic [SLOT_W-1:0] exp_wr_addr;
   logic [SW-1:0]     exp_wr_data;
   logic              exp_rd_en;
   logic [SLOT_W-1:0] exp_rd_addr;
   logic [SW-1:0]     exp_rd_data;
   logic              emit_valid;
   rsp_type           emit_data;
   logic              emit_free;

   // Sequencer for all three item kinds.
   srw_ctrl #(
      .MAX_SEQ_BITS (MAX_SEQ_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_slot    (req_slot),
      .req_outcome (req_outcome),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .win_wr_en   (win_wr_en),
      .win_wr_addr (win_wr_addr),
      .win_wr_data (win_wr_data),
      .win_rd_en   (win_rd_en),
      .win_rd_addr (win_rd_addr),
      .win_rd_data (win_rd_data),
      .exp_wr_en   (exp_wr_en),
      .exp_wr_addr (exp_wr_addr),
      .exp_wr_data (exp_wr_data),
      .exp_rd_en   (exp_rd_en),
      .exp_rd_addr (exp_rd_addr),
      .exp_rd_data (exp_rd_data),
      .emit_valid  (emit_valid),
      .emit_data   (emit_data),
      .emit_free   (emit_free)
   );

   // Sender window: acknowledged flag above the sequence number.
   srw_ram #(
      .WIDTH (SW + 1),
      .DEPTH (WIN_DEPTH)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (win_wr_addr),
      .wr_data (win_wr_data),
      .rd_en   (win_rd_en),
      .rd_addr (win_rd_addr),
      .rd_data (win_rd_data)
   );

   // Receiver list of expected sequence numbers.
   srw_ram #(
      .WIDTH (SW),
      .DEPTH (WIN_DEPTH)
   ) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (exp_wr_addr),
      .wr_data (exp_wr_data),
      .rd_en   (exp_rd_en),
      .rd_addr (exp_rd_addr),
      .rd_data (exp_rd_data)
   );

   // Output register on the result channel.
   srw_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .ld_valid         (emit_valid),
      .ld_data          (emit_data),
      .free             (emit_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_seq_num      (rsp_seq_num),
      .rsp_ack_received (rsp_ack_received),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ----- bench/tb_selective_repeat_window.sv -----
`timescale 1ns / 1ps

module tb_selective_repeat_window import srw_pkg::*; ();

   // Mode value that the block has no use for and must answer as ignored.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Tracks the sender window and the receiver's expected list, and holds the
   // results that each accepted request should produce, oldest first.
   class window_tracker;
      logic [CSR_W-1:0]     seq_bits;
      logic [SEQ_OUT_W-1:0] slot_seq [WIN_DEPTH];
      logic                 slot_acked [WIN_DEPTH];
      logic [SEQ_OUT_W-1:0] rx_expected [WIN_DEPTH];
      logic [SEQ_OUT_W-1:0] tx_next;
      logic [SEQ_OUT_W-1:0] rx_next;
      rsp_type              pending_results [$];
      int                   errors;

      function new();
         seq_bits = SEQ_BITS_RESET;
         foreach (slot_seq[i]) begin
            slot_seq[i] = '0;
            slot_acked[i] = 1'b0;
            rx_expected[i] = '0;
         end
         tx_next = '0;
         rx_next = '0;
         errors = 0;
      endfunction

      // The register is saturated to 1 .. MAX_SEQ_BITS before use.
      function int unsigned seq_width();
         int unsigned b;
         b = seq_bits;
         if (b < 1) b = 1;
         if (b > MAX_SEQ_BITS_DEF) b = MAX_SEQ_BITS_DEF;
         return b;
      endfunction

      function logic [SEQ_OUT_W-1:0] seq_mask();
         return SEQ_OUT_W'((1 << seq_width()) - 1);
      endfunction

      function int unsigned win_size();
         int unsigned w;
         w = (1 << seq_width()) >> 1;
         return (w > WIN_DEPTH) ? WIN_DEPTH : w;
      endfunction

      function void set_bits(logic [CSR_W-1:0] value);
         seq_bits = value;
      endfunction

      function void expect_result(logic [STATUS_W-1:0] status, logic [SEQ_OUT_W-1:0] seq,
                                  logic ack, logic last);
         rsp_type r;
         r.status = status;
         r.seq_num = seq;
         r.ack_received = ack;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      // Applies one accepted request to the window and queues its results.
      function void note_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                 logic [OC_W-1:0] oc);
         logic [SEQ_OUT_W-1:0] mask;
         logic [STATUS_W-1:0]  status;
         int unsigned          w, j, k, kept, unacked, listed;
         mask = seq_mask();
         w = win_size();
         case (mode)
            MODE_START: begin
               for (k = 0; k < w; k++) begin
                  slot_seq[k] = SEQ_OUT_W'(k) & mask;
                  rx_expected[k] = SEQ_OUT_W'(k) & mask;
                  slot_acked[k] = 1'b0;
               end
               tx_next = SEQ_OUT_W'(w) & mask;
               rx_next = SEQ_OUT_W'(w) & mask;
               for (k = 0; k < w; k++)
                  expect_result(ST_SENT, slot_seq[k], 1'b0, k + 1 == w);
            end
            MODE_OUTCOME: begin
               if (slot >= w) begin
                  expect_result(ST_IGNORED, '0, 1'b0, 1'b1);
               end else if (slot_acked[slot]) begin
                  expect_result(ST_IGNORED, slot_seq[slot], 1'b1, 1'b1);
               end else if (oc == OC_ACK_OK || oc == OC_ACK_LOST) begin
                  // Delivered: the receiver takes the first matching entry.
                  status = ST_DUPLICATE;
                  for (j = 0; j < w; j++) begin
                     if (rx_expected[j] == slot_seq[slot]) begin
                        rx_expected[j] = rx_next & mask;
                        rx_next = ((rx_next & mask) + 1'b1) & mask;
                        status = ST_ACCEPTED;
                        break;
                     end
                  end
                  slot_acked[slot] = (oc == OC_ACK_OK);
                  expect_result(status, slot_seq[slot], slot_acked[slot], 1'b1);
               end else begin
                  slot_acked[slot] = 1'b0;
                  expect_result((oc == OC_DAMAGED) ? ST_NAK : ST_LOST, slot_seq[slot],
                                1'b0, 1'b1);
               end
            end
            MODE_SLIDE: begin
               // Drop the leading acknowledged slots, refill at the top.
               j = 0;
               while (j < w && slot_acked[j]) j++;
               kept = 0;
               for (k = j; k < w; k++) begin
                  slot_seq[kept] = slot_seq[k];
                  slot_acked[kept] = slot_acked[k];
                  kept++;
               end
               for (k = kept; k < w; k++) begin
                  slot_seq[k] = tx_next & mask;
                  tx_next = ((tx_next & mask) + 1'b1) & mask;
                  slot_acked[k] = 1'b0;
               end
               unacked = 0;
               for (k = 0; k < w; k++)
                  if (!slot_acked[k]) unacked++;
               listed = 0;
               for (k = 0; k < w; k++) begin
                  if (!slot_acked[k]) begin
                     listed++;
                     expect_result(ST_SENT, slot_seq[k], 1'b0, listed == unacked);
                  end
               end
            end
            default: expect_result(ST_IGNORED, '0, 1'b0, 1'b1);
         endcase
      endfunction

      task report(string what);
         errors++;
         $display("ERROR at %0t ns: %s", $time, what);
      endtask

      // Compares one result transfer with the oldest outstanding expectation.
      task check_result(logic [STATUS_W-1:0] status, logic [SEQ_OUT_W-1:0] seq,
                        logic ack, logic last);
         rsp_type e;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result status %0d seq %0d", status, seq));
         end else begin
            e = pending_results.pop_front();
            if (status !== e.status)
               report($sformatf("status %0d, wanted %0d", status, e.status));
            if (seq !== e.seq_num)
               report($sformatf("seq_num %0d, wanted %0d", seq, e.seq_num));
            if (ack !== e.ack_received)
               report($sformatf("ack_received %0b, wanted %0b", ack, e.ack_received));
            if (last !== e.last)
               report($sformatf("last %0b, wanted %0b", last, e.last));
         end
      endtask

      task finish_check();
         if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode;
   logic [SLOT_W-1:0]    req_slot;
   logic [OC_W-1:0]      req_outcome;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SEQ_OUT_W-1:0] rsp_seq_num;
   logic                 rsp_ack_received;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_data;

   window_tracker tracker;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Sequence-bit settings visited in turn; the first is the reset value.
   logic [CSR_W-1:0] width_plan [9] = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6, 3'd3};

   selective_repeat_window DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_outcome      (req_outcome),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_seq_num      (rsp_seq_num),
      .rsp_ack_received (rsp_ack_received),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every result transfer is checked at the edge where it happens.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_status, rsp_seq_num, rsp_ack_received, rsp_last);
   end

   // Presents one request and returns at the falling edge after its transfer.
   // Valid stays high afterwards so that back-to-back requests are possible.
   task automatic send_item(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                            logic [OC_W-1:0] oc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_slot = slot;
      req_outcome = oc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(mode, slot, oc);
      @(negedge clock);
   endtask

   // Waits until the block has delivered everything and has gone quiet.
   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (32) @(negedge clock);
   endtask

   task automatic write_seq_bits(logic [CSR_W-1:0] value);
      drain();
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_bits(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Hand-picked requests with a window of four slots, starting from reset.
   task automatic directed_items();
      send_item(MODE_OUTCOME, 3'd0, OC_ACK_OK);   // outcome on the reset window
      send_item(MODE_UNUSED, 3'd7, OC_LOST);
      send_item(MODE_SLIDE, 3'd0, OC_ACK_OK);
      send_item(MODE_START, 3'd0, OC_ACK_OK);
      send_item(MODE_OUTCOME, 3'd0, OC_ACK_OK);
      send_item(MODE_OUTCOME, 3'd0, OC_ACK_LOST); // slot already acknowledged
      send_item(MODE_OUTCOME, 3'd1, OC_ACK_LOST);
      send_item(MODE_OUTCOME, 3'd1, OC_ACK_OK);   // second delivery is a duplicate
      send_item(MODE_OUTCOME, 3'd2, OC_DAMAGED);
      send_item(MODE_OUTCOME, 3'd3, OC_LOST);
      send_item(MODE_OUTCOME, 3'd4, OC_ACK_OK);   // outside the window
      send_item(MODE_OUTCOME, 3'd7, OC_DAMAGED);
      send_item(MODE_SLIDE, 3'd0, OC_ACK_OK);
      send_item(MODE_OUTCOME, 3'd2, OC_ACK_OK);
      send_item(MODE_OUTCOME, 3'd3, OC_ACK_OK);
      send_item(MODE_OUTCOME, 3'd0, OC_ACK_OK);
      send_item(MODE_OUTCOME, 3'd1, OC_ACK_OK);
      send_item(MODE_SLIDE, 3'd5, OC_LOST);       // whole window acknowledged
      send_item(MODE_START, 3'd6, OC_DAMAGED);
      send_item(MODE_SLIDE, 3'd0, OC_ACK_OK);
   endtask

   // Mostly sessions of rounds (outcomes then a slide), with some noise.
   task automatic random_traffic(int target);
      int unsigned          w, rounds, n;
      int                   counted;
      logic [SLOT_W-1:0]    slot;
      logic [OC_W-1:0]      oc;
      counted = 0;
      while (counted < target) begin
         w = tracker.win_size();
         if ($urandom_range(99) < 10) begin
            if (w < WIN_DEPTH && $urandom_range(1))
               send_item(MODE_OUTCOME, SLOT_W'($urandom_range(WIN_DEPTH - 1, w)),
                         OC_W'($urandom_range(3)));
            else
               send_item(MODE_UNUSED, SLOT_W'($urandom_range(7)), OC_W'($urandom_range(3)));
         end else begin
            if ($urandom_range(99) < 85) begin
               send_item(MODE_START, SLOT_W'($urandom_range(7)), OC_W'($urandom_range(3)));
               counted++;
            end
            rounds = $urandom_range(3, 1);
            repeat (rounds) begin
               n = $urandom_range(2 * w);
               repeat (n) begin
                  if ($urandom_range(99) < 92)
                     slot = SLOT_W'($urandom_range(w - 1));
                  else
                     slot = SLOT_W'($urandom_range(7));
                  oc = ($urandom_range(99) < 45) ? OC_ACK_OK : OC_W'($urandom_range(3));
                  send_item(MODE_OUTCOME, slot, oc);
                  if (slot < w) counted++;
               end
               send_item(MODE_SLIDE, SLOT_W'($urandom_range(7)), OC_W'($urandom_range(3)));
               counted++;
            end
         end
      end
   endtask

   // Main sequence: reset, directed requests, then one random phase per setting.
   initial begin
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_START;
      req_slot = '0;
      req_outcome = OC_ACK_OK;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      directed_items();
      for (int p = 0; p < 9; p++) begin
         if (p != 0) write_seq_bits(width_plan[p]);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 77;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 77;
            end
            default: begin
               send_idle_pct = 38;
               rsp_stall_pct = 38;
            end
         endcase
         random_traffic(32);
      end

      drain();
      tracker.finish_check();
      if (tracker.errors == 0)
         $display("PASS selective_repeat_window");
      else
         $display("FAIL selective_repeat_window");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("FAIL selective_repeat_window");
      $finish;
   end

endmodule
